@@ rtl/alie_pkg.sv @@
// Types and constants shared by the array list insert/erase block.
`default_nettype none

package alie_pkg;

    localparam int CAPACITY   = 256;
    localparam int WORD_WIDTH = 32;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = AW + 1;

    typedef enum logic [2:0] {
        OP_INSERT_AT = 3'd0,
        OP_ERASE_AT  = 3'd1,
        OP_PUSH_BACK = 3'd2,
        OP_POP_BACK  = 3'd3,
        OP_FIND      = 3'd4,
        OP_READ_AT   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [8:0]         pos;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [7:0]         index;
        logic signed [31:0] data;
        logic [8:0]         count;
    } t_rsp;

endpackage

`default_nettype wire

@@ rtl/array_list_insert_erase_core.sv @@
// Top level of the ordered list with positional insert, erase, find and read.
// Rejected requests and spare op codes skip the storage walk; read_at reads one entry,
// insert and erase shift each entry past the position, and a find reads entries until
// it hits or reaches the end of the list.
// Throughput: one request at a time through the single storage instance; ready returns as the
// result enters the output register and holds low while that register is still occupied.
// Reset: synchronous, active low; clears the entry count and all handshake state.
`default_nettype none

module array_list_insert_erase_core
    import alie_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;

    // Walk context: operation, position, value, read pointer and reads left
    t_op             r_op, n_op;
    logic [AW-1:0]   r_pos, n_pos;
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_left, n_left;

    // Read pipeline: a read issued last cycle has its data on rdata now
    logic            r_rv, n_rv;
    logic [AW-1:0]   r_raddr, n_raddr;

    // Pending result and output register
    t_rsp            r_res, n_res;
    t_rsp            r_out, n_out;

    // Storage port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [WORD_WIDTH-1:0] mem_rdata;

    // Decisions shared by the next-state logic
    logic acc;
    logic acc_reject;
    logic walk_finish;
    logic out_free;

    alie_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign acc         = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = acc_reject ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (walk_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_rv        = 1'b0;
        n_raddr     = r_raddr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_raddr;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        acc_reject  = 1'b0;
        walk_finish = 1'b0;

        // Drop the output once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // Decode the request and set up the walk or the early result
                n_val        = i_in_data.value[WORD_WIDTH-1:0];
                n_res.status = ST_OK;
                n_res.index  = '0;
                n_res.data   = '0;
                n_res.count  = r_count;
                n_op         = i_in_data.op;
                n_pos        = i_in_data.pos[AW-1:0];
                n_left       = '0;
                n_ptr        = '0;
                unique case (i_in_data.op)
                    OP_INSERT_AT, OP_PUSH_BACK: begin
                        if (i_in_data.op == OP_INSERT_AT && i_in_data.pos > r_count) begin
                            acc_reject   = 1'b1;
                            n_res.status = ST_BAD;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            acc_reject   = 1'b1;
                            n_res.status = ST_FULL;
                        end else begin
                            n_op = OP_INSERT_AT;
                            if (i_in_data.op == OP_PUSH_BACK) begin
                                n_pos = r_count[AW-1:0];
                            end
                            n_left = r_count - {1'b0, n_pos};
                            n_ptr  = r_count[AW-1:0] - AW'(1);
                        end
                    end
                    OP_ERASE_AT, OP_POP_BACK: begin
                        if (i_in_data.op == OP_ERASE_AT && i_in_data.pos >= r_count) begin
                            acc_reject   = 1'b1;
                            n_res.status = ST_BAD;
                        end else if (r_count == '0) begin
                            acc_reject   = 1'b1;
                            n_res.status = ST_BAD;
                        end else begin
                            n_op = OP_ERASE_AT;
                            if (i_in_data.op == OP_POP_BACK) begin
                                n_pos = r_count[AW-1:0] - AW'(1);
                            end
                            n_left = r_count - CW'(1) - {1'b0, n_pos};
                            n_ptr  = n_pos + AW'(1);
                        end
                    end
                    OP_FIND: begin
                        n_left = r_count;
                    end
                    OP_READ_AT: begin
                        if (i_in_data.pos >= r_count) begin
                            acc_reject   = 1'b1;
                            n_res.status = ST_BAD;
                        end else begin
                            n_left = CW'(1);
                            n_ptr  = i_in_data.pos[AW-1:0];
                        end
                    end
                    default: begin
                        // Unused codes change nothing and report ok
                        acc_reject = 1'b1;
                    end
                endcase
                if (!acc) begin
                    n_res  = r_res;
                    n_op   = r_op;
                    n_pos  = r_pos;
                    n_val  = r_val;
                    n_left = r_left;
                    n_ptr  = r_ptr;
                end
            end

            S_WALK: begin
                // Issue the next read while entries remain
                if (r_left != '0) begin
                    mem_re  = 1'b1;
                    n_rv    = 1'b1;
                    n_raddr = r_ptr;
                    n_left  = r_left - CW'(1);
                    n_ptr   = (r_op == OP_INSERT_AT) ? r_ptr - AW'(1) : r_ptr + AW'(1);
                end

                // Consume the data read last cycle
                if (r_rv) begin
                    unique case (r_op)
                        OP_INSERT_AT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_raddr + AW'(1);
                        end
                        OP_ERASE_AT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_raddr - AW'(1);
                        end
                        OP_FIND: begin
                            if (mem_rdata == r_val) begin
                                walk_finish  = 1'b1;
                                n_res.status = ST_OK;
                                n_res.index  = 8'(r_raddr);
                            end
                        end
                        OP_READ_AT: begin
                            walk_finish  = 1'b1;
                            n_res.status = ST_OK;
                            n_res.data   = 32'($signed(mem_rdata));
                        end
                        default: begin
                            walk_finish = 1'b1;
                        end
                    endcase
                end else if (r_left == '0) begin
                    // Pipeline drained: close the operation
                    walk_finish = 1'b1;
                    unique case (r_op)
                        OP_INSERT_AT: begin
                            mem_we      = 1'b1;
                            mem_waddr   = r_pos;
                            mem_wdata   = r_val;
                            n_count     = r_count + CW'(1);
                            n_res.count = r_count + CW'(1);
                        end
                        OP_ERASE_AT: begin
                            n_count     = r_count - CW'(1);
                            n_res.count = r_count - CW'(1);
                        end
                        OP_FIND: begin
                            n_res.status = ST_MISS;
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end

                // Hold off further reads once the result is settled
                if (walk_finish) begin
                    n_rv = 1'b0;
                end
            end

            S_DONE: begin
                // Advance the result into the output register when it is free
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end

            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rv        <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rv        <= n_rv;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_ptr   <= n_ptr;
        r_raddr <= n_raddr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/alie_ram.sv @@
// Single-port-write, single-port-read list storage with registered read data.
`default_nettype none

module alie_ram
    import alie_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WORD_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [CAPACITY];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
